@@ sv/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int DATA_W = 32;
   localparam int FILL_W = 5;

   typedef logic [1:0]               cmd_type;
   typedef logic [1:0]               status_type;
   typedef logic signed [DATA_W-1:0] word_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_PEEK   = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef struct packed {
      word_type value;
      word_type rank;
   } entry_type;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic      do_insert;
      logic      do_delete;
      logic      order_mode;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

@@ sv/spq_channels.sv @@
// Handshake channel interfaces of the sorted priority queue.
interface spq_req_if;
   import spq_pkg::*;
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   word_type item_value;
   word_type item_rank;
   modport source (output valid, output cmd, output item_value, output item_rank,
                   input ready);
   modport sink (input valid, input cmd, input item_value, input item_rank,
                 output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic              valid;
   logic              ready;
   status_type        status;
   word_type          front_value;
   word_type          front_rank;
   logic [FILL_W-1:0] fill_count;
   modport source (output valid, output status, output front_value, output front_rank,
                   output fill_count, input ready);
   modport sink (input valid, input status, input front_value, input front_rank,
                 input fill_count, output ready);
endinterface

interface spq_csr_if;
   logic valid;
   logic ready;
   logic order_mode;
   modport source (output valid, output order_mode, input ready);
   modport sink (input valid, input order_mode, output ready);
endinterface

@@ sv/spq_cell.sv @@
// One storage cell of the queue: holds an entry, shifts toward or away from the front.
module spq_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 5
) (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       count,
   input  spq_pkg::entry_type     left_entry,
   input  spq_pkg::entry_type     right_entry,
   input  logic                   run_in,
   output logic                   run_out,
   output spq_pkg::entry_type     entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      here_ok;

   assign occupied = count > CNT_W'(CELL_INDEX);

   // Stored rank is equal or better than the incoming one.
   always_comb begin
      if (ctrl.order_mode) begin
         here_ok = occupied && ($signed(entry_ff.rank) <= $signed(ctrl.new_entry.rank));
      end else begin
         here_ok = occupied && ($signed(entry_ff.rank) >= $signed(ctrl.new_entry.rank));
      end
   end

   assign run_out = run_in && here_ok;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.do_insert) begin
         // inside the leading run hold, at its end take the new item, behind it shift back
         if (run_in && !here_ok) begin
            entry_in = ctrl.new_entry;
         end else if (!run_in) begin
            entry_in = left_entry;
         end
      end else if (ctrl.do_delete) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue: a row of cells kept in service order, front at cell zero.
//
// Channels: req_ch carries a command (insert, delete front, peek front) with a
// value and rank; rsp_ch returns one item per command with status, the front
// entry for a successful delete or peek (zero otherwise) and the fill count after
// the command. csr_ch writes order_mode (0: highest rank first, 1: lowest first)
// and is always ready; write it only while the queue is idle.
// The response is registered at the edge that takes the command. One command per
// cycle is sustained while rsp_ch does not stall: every cell compares its rank with
// the incoming one in parallel and moves in the same edge, so the cell row and the
// single output register set the rate.
// An insert lands after all entries of equal or better rank. An insert into a
// full queue is dropped with a full status; delete or peek on an empty queue
// returns an empty status.
// Reset empties the queue and sets order_mode to 0; entry storage is not cleared.
// When rsp_ch stalls, the held response stays and req_ch.ready drops until it is
// taken.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch,
   spq_csr_if.sink   csr_ch
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              mode_ff;
   logic              rsp_valid_ff;
   status_type        status_ff;
   status_type        status_in;
   word_type          front_value_ff;
   word_type          front_value_in;
   word_type          front_rank_ff;
   word_type          front_rank_in;
   logic [FILL_W-1:0] fill_ff;

   logic              accept;
   logic              full;
   logic              empty;
   cell_ctrl_type     ctrl;
   entry_type         cell_q [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] run;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty        = count_ff == '0;

   assign ctrl.do_insert       = accept && (req_ch.cmd == CMD_INSERT) && !full;
   assign ctrl.do_delete       = accept && (req_ch.cmd == CMD_DELETE) && !empty;
   assign ctrl.order_mode      = mode_ff;
   assign ctrl.new_entry.value = req_ch.item_value;
   assign ctrl.new_entry.rank  = req_ch.item_rank;

   assign run[0] = 1'b1;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == QUEUE_DEPTH - 1) ? i : i + 1;
      spq_cell #(
         .CELL_INDEX (i),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  ((i == 0) ? ctrl.new_entry : cell_q[LEFT]),
         .right_entry (cell_q[RIGHT]),
         .run_in      (run[i]),
         .run_out     (run[i+1]),
         .entry       (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      status_in      = ST_OK;
      front_value_in = '0;
      front_rank_in  = '0;
      unique case (req_ch.cmd)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end
         end
         CMD_DELETE, CMD_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_value_in = cell_q[0].value;
               front_rank_in  = cell_q[0].rank;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_ch.valid) begin
            mode_ff <= csr_ch.order_mode;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         front_value_ff <= front_value_in;
         front_rank_ff  <= front_rank_in;
         fill_ff        <= FILL_W'(count_in);
      end
   end

   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.front_value = front_value_ff;
   assign rsp_ch.front_rank  = front_rank_ff;
   assign rsp_ch.fill_count  = fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.cmd == CMD_INSERT) && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted insert did not add an entry");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.cmd == CMD_INSERT) && full |=> count_ff == CNT_W'(QUEUE_DEPTH))
      else $error("dropped insert changed the count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_EMPTY) |-> (front_value_ff == '0) && (front_rank_ff == '0))
      else $error("underflow response carries data");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the sorted priority queue: directed and random commands.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 130;
   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam word_type WORD_MAX = 32'h7fffffff;
   localparam word_type WORD_MIN = 32'h80000000;

   // Mirrors the queue contents and predicts one response per accepted command.
   class queue_scoreboard;
      typedef struct {
         status_type        status;
         word_type          value;
         word_type          rank;
         logic [FILL_W-1:0] fill;
      } response_type;

      int capacity;
      logic order_mode;
      entry_type held[$];
      response_type awaited[$];
      int mismatches, checked;
      int n_insert, n_full, n_delete, n_peek, n_unused, n_empty;

      function new(int depth);
         capacity = depth;
         order_mode = 1'b0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // True when a stored rank is equal to or better than the incoming one.
      function bit ranks_ahead(word_type held_rank, word_type new_rank);
         if (order_mode)
            return $signed(held_rank) <= $signed(new_rank);
         return $signed(held_rank) >= $signed(new_rank);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      function void note_command(cmd_type cmd, word_type value, word_type rank);
         response_type r;
         entry_type e;
         int pos;
         r.status = ST_OK;
         r.value = '0;
         r.rank = '0;
         case (cmd)
            CMD_INSERT: begin
               n_insert++;
               if (held.size() >= capacity) begin
                  r.status = ST_FULL;
                  n_full++;
               end else begin
                  pos = 0;
                  while (pos < held.size() && ranks_ahead(held[pos].rank, rank))
                     pos++;
                  e.value = value;
                  e.rank = rank;
                  held.insert(pos, e);
               end
            end
            CMD_DELETE, CMD_PEEK: begin
               if (cmd == CMD_DELETE)
                  n_delete++;
               else
                  n_peek++;
               if (held.size() == 0) begin
                  r.status = ST_EMPTY;
                  n_empty++;
               end else begin
                  r.value = held[0].value;
                  r.rank = held[0].rank;
                  if (cmd == CMD_DELETE)
                     void'(held.pop_front());
               end
            end
            default: n_unused++;
         endcase
         r.fill = FILL_W'(held.size());
         awaited.push_back(r);
      endfunction

      function void check_response(status_type status, word_type value, word_type rank,
                                   logic [FILL_W-1:0] fill);
         response_type want;
         checked++;
         if (awaited.size() == 0) begin
            flag($sformatf("response %0d arrived with nothing outstanding", checked));
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status || value !== want.value || rank !== want.rank
             || fill !== want.fill)
            flag($sformatf({"response %0d: expected status %0d value %0d rank %0d fill %0d,",
                            " got status %0d value %0d rank %0d fill %0d"},
                           checked, want.status, want.value, want.rank, want.fill,
                           status, value, rank, fill));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int cycle_count;
   int mode_writes;
   queue_scoreboard sb;

   spq_req_if req_ch();
   spq_rsp_if rsp_ch();
   spq_csr_if csr_ch();

   sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long.
   function int pick_gap();
      int x;
      x = $urandom_range(0, 99);
      if (x < 65)
         return 0;
      if (x < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Mix full-range ranks with a narrow band (many ties) and the extremes.
   function word_type pick_rank();
      int x;
      x = $urandom_range(0, 9);
      if (x < 4)
         return $urandom;
      if (x < 8)
         return $signed($urandom_range(0, 6)) - 3;
      case ($urandom_range(0, 3))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         default: return -1;
      endcase
   endfunction

   function cmd_type pick_command(int insert_pct);
      int x;
      x = $urandom_range(0, 99);
      if (x < 2)
         return CMD_UNUSED;
      if (x < 2 + insert_pct)
         return CMD_INSERT;
      if ($urandom_range(0, 3) == 0)
         return CMD_PEEK;
      return CMD_DELETE;
   endfunction

   task automatic send_command(cmd_type cmd, word_type value, word_type rank, bit no_gap);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.item_value <= value;
      req_ch.item_rank <= rank;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_command(cmd, value, rank);
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle(int settle);
      req_ch.valid <= 1'b0;
      while (sb.pending() > 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      csr_ch.valid <= 1'b1;
      csr_ch.order_mode <= mode;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      sb.order_mode = mode;
      mode_writes++;
   endtask

   // Response side: ready runs of varying length broken by random stalls.
   initial begin
      int stall;
      forever begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(20, 60)) @(posedge clock);
         else
            repeat ($urandom_range(1, 6)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_response(rsp_ch.status, rsp_ch.front_value, rsp_ch.front_rank,
                           rsp_ch.fill_count);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int insert_pct;
      bit quiet;
      logic mode;
      int weights [PHASES] = '{50, 80, 30, 95, 50, 20, 70, 90, 40, 60};
      sb = new(DEPTH);
      mode_writes = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_INSERT;
      req_ch.item_value <= '0;
      req_ch.item_rank <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.order_mode <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Highest rank first: empty queue, extremes, ties in arrival order.
      write_mode(1'b0);
      send_command(CMD_DELETE, 32'h12345678, 32'h1, 1'b0);
      send_command(CMD_PEEK, '0, '0, 1'b0);
      send_command(CMD_UNUSED, '0, '0, 1'b0);
      send_command(CMD_INSERT, WORD_MAX, WORD_MAX, 1'b0);
      send_command(CMD_INSERT, WORD_MIN, WORD_MIN, 1'b0);
      send_command(CMD_INSERT, '0, '0, 1'b0);
      send_command(CMD_INSERT, 32'd1, '0, 1'b0);
      send_command(CMD_INSERT, -1, -1, 1'b0);
      send_command(CMD_INSERT, 32'd2, WORD_MAX, 1'b0);
      send_command(CMD_PEEK, '0, '0, 1'b0);
      send_command(CMD_UNUSED, -1, -1, 1'b0);
      send_command(CMD_DELETE, '0, '0, 1'b0);
      send_command(CMD_DELETE, '0, '0, 1'b0);
      send_command(CMD_DELETE, '0, '0, 1'b0);

      // Lowest rank first with entries still held from the other order.
      wait_idle(2);
      write_mode(1'b1);
      send_command(CMD_INSERT, 32'd5, -1, 1'b0);
      send_command(CMD_INSERT, 32'd6, WORD_MIN, 1'b0);
      send_command(CMD_PEEK, '0, '0, 1'b0);
      repeat (6) send_command(CMD_DELETE, '0, '0, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle(2);
         mode = (phase % 3 == 2) ? 1'($urandom_range(0, 1)) : 1'(phase % 2);
         write_mode(mode);
         insert_pct = weights[phase];
         quiet = (phase % 4 == 3);
         repeat (PHASE_ITEMS)
            send_command(pick_command(insert_pct), $urandom, pick_rank(), quiet);
      end

      wait_idle(5);
      $display("Ran %0d commands over %0d order settings: %0d inserts (%0d dropped as full),",
               sb.n_insert + sb.n_delete + sb.n_peek + sb.n_unused, mode_writes,
               sb.n_insert, sb.n_full);
      $display("%0d deletes, %0d peeks, %0d unused codes, %0d underflows; %0d mismatches",
               sb.n_delete, sb.n_peek, sb.n_unused, sb.n_empty, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
